@@ design/i2cme_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cme_pkg
// shared types, command codes and constants of the i2c master byte engine
// ----------------------------------------------------------------------------
package i2cme_pkg;

    // command codes carried by a tick
    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_START   = 3'd1;
    localparam logic [2:0] CMD_STOP    = 3'd2;
    localparam logic [2:0] CMD_WRITE   = 3'd3;
    localparam logic [2:0] CMD_READ    = 3'd4;
    localparam logic [2:0] CMD_RECOVER = 3'd5;

    // configuration register indexes
    localparam logic CFG_HALF_PERIOD = 1'b0;
    localparam logic CFG_ACK_TIMEOUT = 1'b1;

    localparam logic [15:0] HALF_PERIOD_RST = 16'd267;
    localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;
    localparam int          RECOVERY_PULSES_DEF = 9;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_ST_A    = 5'd1,
        PH_ST_B    = 5'd2,
        PH_ST_C    = 5'd3,
        PH_SP_A    = 5'd4,
        PH_SP_B    = 5'd5,
        PH_SP_C    = 5'd6,
        PH_WR_D    = 5'd7,
        PH_WR_H    = 5'd8,
        PH_WR_L    = 5'd9,
        PH_AK_REL  = 5'd10,
        PH_AK_RISE = 5'd11,
        PH_AK_POLL = 5'd12,
        PH_AK_END  = 5'd13,
        PH_RD_L    = 5'd14,
        PH_RD_H    = 5'd15,
        PH_RA_A    = 5'd16,
        PH_RA_B    = 5'd17,
        PH_RA_C    = 5'd18,
        PH_RC_H    = 5'd19,
        PH_RC_L    = 5'd20,
        PH_FIN     = 5'd21
    } t_phase;

    // sequencer state carried from tick to tick
    typedef struct packed {
        t_phase      phase;
        logic [3:0]  bit_cnt;
        logic [15:0] wait_cnt;
        logic [7:0]  tmo_cnt;
        logic [7:0]  shift;
        logic        ack_choice;
        logic        err;
        logic [7:0]  rx;
        logic        scl;
        logic        sda;
        logic        drv;
    } t_state;

    // one tick as held in the input register
    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] tx_byte;
        logic       master_ack;
        logic       sda_sample;
    } t_tick;

endpackage

@@ design/i2cme_step.sv @@
// ----------------------------------------------------------------------------
// i2cme_step
// next-state logic of the bus sequencer for one tick
// ----------------------------------------------------------------------------
module i2cme_step #(
    parameter int RECOVERY_PULSES = i2cme_pkg::RECOVERY_PULSES_DEF
) (
    input  i2cme_pkg::t_state i_state,
    input  i2cme_pkg::t_tick  i_tick,
    input  logic [15:0]       i_half_period,
    input  logic [7:0]        i_ack_timeout,
    output i2cme_pkg::t_state o_state,
    output logic              o_done
);
    import i2cme_pkg::*;

    localparam logic [3:0] PULSES = 4'(RECOVERY_PULSES);

    t_state     b;
    t_state     n;
    logic       take;
    logic       do_act;
    logic [3:0] cnt_inc;
    logic [7:0] rd_shift;

    always_comb begin
        b      = i_state;
        take   = 1'b0;
        o_done = 1'b0;

        // command decode when idle
        if (i_state.phase == PH_IDLE) begin
            b.bit_cnt = '0;
            take      = 1'b1;
            case (i_tick.cmd)
                CMD_START:   b.phase = PH_ST_A;
                CMD_STOP:    b.phase = PH_SP_A;
                CMD_WRITE: begin
                    b.shift = i_tick.tx_byte;
                    b.err   = 1'b0;
                    b.phase = PH_WR_D;
                end
                CMD_READ: begin
                    b.shift      = '0;
                    b.ack_choice = i_tick.master_ack;
                    b.phase      = PH_RD_L;
                end
                CMD_RECOVER: b.phase = PH_RC_H;
                default:     take = 1'b0;
            endcase
            do_act = take;
        end else begin
            do_act = (i_state.wait_cnt == '0);
        end

        cnt_inc  = b.bit_cnt + 4'd1;
        rd_shift = {b.shift[6:0], i_tick.sda_sample};
        n        = b;

        if (i_state.phase != PH_IDLE && !do_act) begin
            n.wait_cnt = b.wait_cnt - 16'd1;
        end else if (do_act) begin
            n.wait_cnt = i_half_period;
            case (b.phase)
                PH_ST_A: begin
                    n.drv = 1'b1; n.sda = 1'b1; n.scl = 1'b1; n.phase = PH_ST_B;
                end
                PH_ST_B: begin n.sda = 1'b0; n.phase = PH_ST_C; end
                PH_ST_C: begin n.scl = 1'b0; n.phase = PH_FIN; end
                PH_SP_A: begin
                    n.drv = 1'b1; n.scl = 1'b0; n.sda = 1'b0; n.phase = PH_SP_B;
                end
                PH_SP_B: begin n.scl = 1'b1; n.phase = PH_SP_C; end
                PH_SP_C: begin n.sda = 1'b1; n.phase = PH_FIN; end
                PH_WR_D: begin
                    n.drv   = 1'b1;
                    n.scl   = 1'b0;
                    n.sda   = b.shift[7];
                    n.shift = {b.shift[6:0], 1'b0};
                    n.phase = PH_WR_H;
                end
                PH_WR_H: begin n.scl = 1'b1; n.phase = PH_WR_L; end
                PH_WR_L: begin
                    n.scl     = 1'b0;
                    n.bit_cnt = cnt_inc;
                    n.phase   = (cnt_inc >= 4'd8) ? PH_AK_REL : PH_WR_D;
                end
                PH_AK_REL: begin n.drv = 1'b0; n.sda = 1'b1; n.phase = PH_AK_RISE; end
                PH_AK_RISE: begin
                    n.scl = 1'b1; n.tmo_cnt = '0; n.phase = PH_AK_POLL;
                end
                PH_AK_POLL: begin
                    if (!i_tick.sda_sample) begin
                        n.scl   = 1'b0;
                        n.err   = 1'b0;
                        n.phase = PH_AK_END;
                    end else if (b.tmo_cnt >= i_ack_timeout) begin
                        // no ack in time: flag and run the stop's first step now
                        n.err   = 1'b1;
                        n.drv   = 1'b1;
                        n.scl   = 1'b0;
                        n.sda   = 1'b0;
                        n.phase = PH_SP_B;
                    end else begin
                        n.tmo_cnt  = b.tmo_cnt + 8'd1;
                        n.wait_cnt = '0;
                    end
                end
                PH_AK_END: begin
                    n.drv      = 1'b1;
                    n.phase    = PH_IDLE;
                    n.wait_cnt = '0;
                    o_done     = 1'b1;
                end
                PH_RD_L: begin
                    n.drv = 1'b0; n.sda = 1'b1; n.scl = 1'b0; n.phase = PH_RD_H;
                end
                PH_RD_H: begin
                    n.scl     = 1'b1;
                    n.shift   = rd_shift;
                    n.bit_cnt = cnt_inc;
                    if (cnt_inc >= 4'd8) begin
                        n.rx    = rd_shift;
                        n.phase = PH_RA_A;
                    end else begin
                        n.phase = PH_RD_L;
                    end
                end
                PH_RA_A: begin
                    n.drv   = 1'b1;
                    n.scl   = 1'b0;
                    n.sda   = ~b.ack_choice;
                    n.phase = PH_RA_B;
                end
                PH_RA_B: begin n.scl = 1'b1; n.phase = PH_RA_C; end
                PH_RA_C: begin n.scl = 1'b0; n.phase = PH_FIN; end
                PH_RC_H: begin
                    n.drv = 1'b0; n.sda = 1'b1; n.scl = 1'b1; n.phase = PH_RC_L;
                end
                PH_RC_L: begin
                    n.scl     = 1'b0;
                    n.bit_cnt = cnt_inc;
                    n.phase   = (cnt_inc >= PULSES) ? PH_SP_A : PH_RC_H;
                end
                default: begin
                    n.phase    = PH_IDLE;
                    n.wait_cnt = '0;
                    o_done     = 1'b1;
                end
            endcase
        end

        o_state = n;
    end

endmodule

@@ design/i2c_master_byte_engine_core.sv @@
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_core
// i2c master primitive engine: start, stop, byte write, byte read, recovery
// ----------------------------------------------------------------------------
//
//  channel   handshake                      payload
//  -------   ----------------------------   ---------------------------------
//  tick in   i_in_valid  / o_in_ready       i_cmd i_tx_byte i_master_ack
//                                           i_sda_sample
//  result    o_out_valid / i_out_ready      o_scl_level o_sda_level
//                                           o_sda_drive o_busy_res o_done_res
//                                           o_rx_byte o_ack_error
//  config    i_cfg_we (no handshake)        i_cfg_idx i_cfg_data
//
//  - one tick is taken per cycle unless the result stalls; each tick yields one
//    result (input register, then sequencer update into the result register)
//  - the sequencer state advances only when the held tick moves into the
//    result register, so a stalled result stalls ticks behind it
//  - with the result register free, o_in_ready stays high every cycle
//  - i_rst_n is synchronous, active low; it returns the bus to scl high,
//    sda driven high, and the registers to 267 and 250
//
module i2c_master_byte_engine_core #(
    parameter int RECOVERY_PULSES = i2cme_pkg::RECOVERY_PULSES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tick input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_cmd,
    input  logic [7:0]  i_tx_byte,
    input  logic        i_master_ack,
    input  logic        i_sda_sample,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_scl_level,
    output logic        o_sda_level,
    output logic        o_sda_drive,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [7:0]  o_rx_byte,
    output logic        o_ack_error,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import i2cme_pkg::*;

    // configuration registers
    logic [15:0] r_half_period;
    logic [7:0]  r_ack_timeout;

    // input register
    logic        r_in_vld;
    t_tick       r_tick;

    // sequencer state and result register
    t_state      r_st;
    t_state      n_st;
    logic        n_done;
    logic        r_out_vld;
    logic        r_done;

    logic        adv;

    // the held tick moves on when the result register is free or draining
    assign adv        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RST;
            r_ack_timeout <= ACK_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HALF_PERIOD: r_half_period <= i_cfg_data;
                CFG_ACK_TIMEOUT: r_ack_timeout <= i_cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_tick <= '{cmd: i_cmd, tx_byte: i_tx_byte,
                        master_ack: i_master_ack, sda_sample: i_sda_sample};
        end
    end

    i2cme_step #(
        .RECOVERY_PULSES (RECOVERY_PULSES)
    ) u_step (
        .i_state       (r_st),
        .i_tick        (r_tick),
        .i_half_period (r_half_period),
        .i_ack_timeout (r_ack_timeout),
        .o_state       (n_st),
        .o_done        (n_done)
    );

    // sequencer state, idle bus: scl high, sda driven high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '{phase: PH_IDLE, bit_cnt: '0, wait_cnt: '0, tmo_cnt: '0,
                      shift: '0, ack_choice: 1'b0, err: 1'b0, rx: '0,
                      scl: 1'b1, sda: 1'b1, drv: 1'b1};
        end else if (adv) begin
            r_st <= n_st;
        end
    end

    // result valid and done flag; the other pin and status fields read straight from the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_done    <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
            r_done    <= n_done;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_scl_level = r_st.scl;
    assign o_sda_level = r_st.sda;
    assign o_sda_drive = r_st.drv;
    assign o_busy_res  = (r_st.phase != PH_IDLE);
    assign o_done_res  = r_done;
    assign o_rx_byte   = r_st.rx;
    assign o_ack_error = r_st.err;

`ifndef SYNTHESIS
    // a finishing tick always leaves the engine idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_done |-> r_st.phase == PH_IDLE)
        else $error("done reported while a primitive is still running");

    // idle never keeps a leftover hold count
    a_idle_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.phase == PH_IDLE |-> r_st.wait_cnt == '0)
        else $error("idle with nonzero hold count");

    // a released sda always reads back high
    a_release_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_st.drv |-> r_st.sda)
        else $error("sda released with a low output level");

    // an ack timeout goes straight into the stop sequence
    a_err_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_st.err) |-> r_st.phase == PH_SP_B && !r_st.scl && !r_st.sda)
        else $error("ack error raised outside the timeout stop");

    // a tick moved on always shows up as a result
    a_adv_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_vld)
        else $error("tick advanced without a result");
`endif

endmodule
